@@ hdl/tbpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tbpc_pkg;

	// Stream payload widths (whole bytes) and field widths
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;
	localparam int TIME_W    = 32;
	localparam int EVENT_W   = 3;
	localparam int CFG_W     = 16;

	// Reset value of the long press threshold in ms
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

	// Pin edge selector carried in tuser
	localparam logic FUNC_ORANGE = 1'b0;
	localparam logic FUNC_BLUE   = 1'b1;

	// Press event codes
	localparam logic [EVENT_W-1:0] EV_NONE               = 3'd0;
	localparam logic [EVENT_W-1:0] EV_BLUE_SHORT         = 3'd1;
	localparam logic [EVENT_W-1:0] EV_BLUE_LONG          = 3'd2;
	localparam logic [EVENT_W-1:0] EV_ORANGE_SHORT       = 3'd3;
	localparam logic [EVENT_W-1:0] EV_ORANGE_LONG        = 3'd4;
	localparam logic [EVENT_W-1:0] EV_CHORD_ORANGE_FIRST = 3'd5;
	localparam logic [EVENT_W-1:0] EV_CHORD_BLUE_FIRST   = 3'd6;
	localparam logic [EVENT_W-1:0] EV_UNUSED             = 3'd7;

	// One pin edge item
	typedef struct packed {
		logic              func;
		logic              blue_level;
		logic              orange_level;
		logic [TIME_W-1:0] now_ms;
	} item_t;

endpackage

`default_nettype wire

@@ hdl/tbpc_classify.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Press/release classification and the per-button state it keeps.
module tbpc_classify (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          fire,
	input  wire tbpc_pkg::item_t               item,
	input  wire logic                          cfg_we,
	input  wire logic [tbpc_pkg::CFG_W-1:0]    cfg_data,
	output      logic [tbpc_pkg::EVENT_W-1:0]  press_event
);

	logic [tbpc_pkg::CFG_W-1:0]  long_press_q;
	logic [tbpc_pkg::TIME_W-1:0] orange_down_time_q;
	logic [tbpc_pkg::TIME_W-1:0] blue_down_time_q;
	logic                        orange_supp_q;
	logic                        blue_supp_q;

	logic                        is_blue;
	logic                        self_up;
	logic                        other_held;
	logic                        self_supp;
	logic [tbpc_pkg::TIME_W-1:0] down_time;
	logic [tbpc_pkg::TIME_W-1:0] held;
	logic [tbpc_pkg::TIME_W-1:0] order_diff;
	logic                        is_long;
	logic                        orange_first;
	logic                        release_live;
	logic                        set_other_supp;

	// Select the edge's own button and the other one
	always_comb begin
		is_blue    = (item.func == tbpc_pkg::FUNC_BLUE);
		self_up    = is_blue ? item.blue_level : item.orange_level;
		other_held = is_blue ? !item.orange_level : !item.blue_level;
		self_supp  = is_blue ? blue_supp_q : orange_supp_q;
		down_time  = is_blue ? blue_down_time_q : orange_down_time_q;
	end

	// Held time and chord order, both modulo 2^32
	assign held         = item.now_ms - down_time;
	assign is_long      = held > {{(tbpc_pkg::TIME_W-tbpc_pkg::CFG_W){1'b0}}, long_press_q};
	assign order_diff   = blue_down_time_q - orange_down_time_q;
	assign orange_first = (order_diff != '0) && !order_diff[tbpc_pkg::TIME_W-1];

	assign release_live   = self_up && !self_supp;
	assign set_other_supp = release_live && other_held;

	// Event decode
	always_comb begin
		press_event = tbpc_pkg::EV_NONE;
		if (release_live) begin
			if (other_held) begin
				if (is_long) begin
					press_event = orange_first ? tbpc_pkg::EV_CHORD_ORANGE_FIRST
					                           : tbpc_pkg::EV_CHORD_BLUE_FIRST;
				end
			end else if (is_long) begin
				press_event = is_blue ? tbpc_pkg::EV_BLUE_LONG : tbpc_pkg::EV_ORANGE_LONG;
			end else begin
				press_event = is_blue ? tbpc_pkg::EV_BLUE_SHORT : tbpc_pkg::EV_ORANGE_SHORT;
			end
		end
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= tbpc_pkg::LONG_PRESS_RESET;
		end else if (cfg_we) begin
			long_press_q <= cfg_data;
		end
	end

	// Press times and suppression flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orange_down_time_q <= '0;
			blue_down_time_q   <= '0;
			orange_supp_q      <= 1'b0;
			blue_supp_q        <= 1'b0;
		end else if (fire) begin
			if (is_blue) begin
				if (!self_up) begin
					blue_down_time_q <= item.now_ms;
				end else begin
					blue_supp_q <= 1'b0;
					if (set_other_supp) begin
						orange_supp_q <= 1'b1;
					end
				end
			end else begin
				if (!self_up) begin
					orange_down_time_q <= item.now_ms;
				end else begin
					orange_supp_q <= 1'b0;
					if (set_other_supp) begin
						blue_supp_q <= 1'b1;
					end
				end
			end
		end
	end

	// A released blue button is never left suppressed
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && self_up && is_blue |=> !blue_supp_q)
		else $error("blue suppression survived its own release");

endmodule

`default_nettype wire

@@ hdl/two_button_press_classifier.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Two-button press classifier.
// Slave stream: one pin edge item per beat. s_tuser is the edge selector
// (0 orange, 1 blue); s_tdata carries both pin levels and the ms timestamp.
// Master stream: one press event per item, in m_tdata[2:0] (0 means none).
// Path: an accepted item is held in the input register, then the classify logic
// feeds the result register, which drives m_tvalid.
// Throughput: one item per cycle without stalls; state updates as the item
// moves into the result register, so the next item sees it in the next cycle.
// Stalls: while m_tready is low the result register holds; the input register
// still takes one more item, then s_tready drops until the result is taken.
// Reset (arst_n low): both stages empty, press times and suppression flags
// cleared, long press threshold back to 1000 ms.
// cfg_data writes the threshold; the cfg channel is always ready. It must be
// written only while the block holds no items; the block does not enforce this.
module two_button_press_classifier (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output      logic                            s_tready,
	// [0] blue_level, [1] orange_level, [33:2] now_ms, [39:34] zero
	input  wire logic [tbpc_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] func
	input  wire logic                            s_tuser,
	output      logic                            m_tvalid,
	input  wire logic                            m_tready,
	// [2:0] press_event, [7:3] zero
	output      logic [tbpc_pkg::M_TDATA_W-1:0]  m_tdata,
	input  wire logic                            cfg_valid,
	output      logic                            cfg_ready,
	input  wire logic [tbpc_pkg::CFG_W-1:0]      cfg_data
);

	tbpc_pkg::item_t               item_s1;
	logic                          valid_s1;
	logic [tbpc_pkg::EVENT_W-1:0]  event_s2;
	logic                          valid_s2;
	logic [tbpc_pkg::EVENT_W-1:0]  event_next;
	logic                          advance;
	logic                          s_fire;

	// Handshake
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign s_fire    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1.func         <= s_tuser;
			item_s1.blue_level   <= s_tdata[0];
			item_s1.orange_level <= s_tdata[1];
			item_s1.now_ms       <= s_tdata[tbpc_pkg::TIME_W+1:2];
		end
	end

	tbpc_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.item        (item_s1),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.press_event (event_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= event_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(tbpc_pkg::M_TDATA_W-tbpc_pkg::EVENT_W){1'b0}}, event_s2};

	// Checks
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[tbpc_pkg::EVENT_W-1:0] != tbpc_pkg::EV_UNUSED)
		else $error("unused event code on output");

	a_press_none: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ((item_s1.func == tbpc_pkg::FUNC_BLUE) ? !item_s1.blue_level
		                                                  : !item_s1.orange_level)
		|=> m_tdata[tbpc_pkg::EVENT_W-1:0] == tbpc_pkg::EV_NONE)
		else $error("press edge produced an event");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("item lost between stages");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("empty input stage not ready");

endmodule

`default_nettype wire

@@ dv/press_event_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the threshold write channel of the press
// classifier, keeps its own copy of the press times and suppression flags,
// and compares every result item with the oldest predicted press event.
module press_event_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	input  wire logic [tbpc_pkg::S_TDATA_W-1:0] s_tdata,
	input  wire logic                           s_tuser,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	input  wire logic [tbpc_pkg::M_TDATA_W-1:0] m_tdata,
	input  wire logic                           cfg_valid,
	input  wire logic                           cfg_ready,
	input  wire logic [tbpc_pkg::CFG_W-1:0]     cfg_data,
	output int                                  pending_count,
	output int                                  failures
);

	// Shadow state of the classifier
	logic [tbpc_pkg::CFG_W-1:0]   long_press_ms;
	logic [tbpc_pkg::TIME_W-1:0]  orange_down_ms;
	logic [tbpc_pkg::TIME_W-1:0]  blue_down_ms;
	logic                         orange_muted;
	logic                         blue_muted;
	logic [tbpc_pkg::EVENT_W-1:0] expected_events[$];

	initial begin
		failures = 0;
		pending_count = 0;
	end

	task automatic report_mismatch(input string what,
			input logic [tbpc_pkg::EVENT_W-1:0] got,
			input logic [tbpc_pkg::EVENT_W-1:0] want);
		$display("%0t: press_event %s: got %0d, expected %0d", $realtime, what, got, want);
		failures++;
	endtask

	// Which button went down first, by serial-number comparison of press times
	function automatic logic [tbpc_pkg::EVENT_W-1:0] chord_order();
		logic [tbpc_pkg::TIME_W-1:0] d;
		d = blue_down_ms - orange_down_ms;
		if (d != '0 && !d[tbpc_pkg::TIME_W-1])
			return tbpc_pkg::EV_CHORD_ORANGE_FIRST;
		return tbpc_pkg::EV_CHORD_BLUE_FIRST;
	endfunction

	// Release of one button; mark_other says the other button gets muted
	function automatic logic [tbpc_pkg::EVENT_W-1:0] release_event(input logic muted,
			input logic [tbpc_pkg::TIME_W-1:0] down_ms,
			input logic [tbpc_pkg::TIME_W-1:0] now,
			input logic other_held, input logic [tbpc_pkg::EVENT_W-1:0] ev_short,
			input logic [tbpc_pkg::EVENT_W-1:0] ev_long, output logic mark_other);
		logic [tbpc_pkg::TIME_W-1:0]  held;
		logic [tbpc_pkg::EVENT_W-1:0] ev;
		ev = tbpc_pkg::EV_NONE;
		mark_other = 1'b0;
		if (!muted) begin
			held = now - down_ms;
			if (held > tbpc_pkg::TIME_W'(long_press_ms)) begin
				if (other_held) begin
					ev = chord_order();
					mark_other = 1'b1;
				end else
					ev = ev_long;
			end else if (other_held)
				mark_other = 1'b1;
			else
				ev = ev_short;
		end
		return ev;
	endfunction

	// Classify one pin edge item and update the shadow state
	function automatic logic [tbpc_pkg::EVENT_W-1:0] classify_edge(input logic func,
			input logic blue_up, input logic orange_up,
			input logic [tbpc_pkg::TIME_W-1:0] now);
		logic [tbpc_pkg::EVENT_W-1:0] ev;
		logic                         mark;
		ev = tbpc_pkg::EV_NONE;
		if (func == tbpc_pkg::FUNC_ORANGE) begin
			if (orange_up) begin
				ev = release_event(orange_muted, orange_down_ms, now, !blue_up,
					tbpc_pkg::EV_ORANGE_SHORT, tbpc_pkg::EV_ORANGE_LONG, mark);
				orange_muted = 1'b0;
				if (mark)
					blue_muted = 1'b1;
			end else
				orange_down_ms = now;
		end else begin
			if (blue_up) begin
				ev = release_event(blue_muted, blue_down_ms, now, !orange_up,
					tbpc_pkg::EV_BLUE_SHORT, tbpc_pkg::EV_BLUE_LONG, mark);
				blue_muted = 1'b0;
				if (mark)
					orange_muted = 1'b1;
			end else
				blue_down_ms = now;
		end
		return ev;
	endfunction

	// Track writes, check results, predict accepted items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ms = tbpc_pkg::LONG_PRESS_RESET;
			orange_down_ms = '0;
			blue_down_ms = '0;
			orange_muted = 1'b0;
			blue_muted = 1'b0;
			expected_events.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				long_press_ms = cfg_data;
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0)
					report_mismatch("with none pending", m_tdata[tbpc_pkg::EVENT_W-1:0],
						tbpc_pkg::EV_NONE);
				else begin
					logic [tbpc_pkg::EVENT_W-1:0] want;
					want = expected_events.pop_front();
					if (m_tdata[tbpc_pkg::EVENT_W-1:0] !== want)
						report_mismatch("mismatch", m_tdata[tbpc_pkg::EVENT_W-1:0], want);
				end
			end
			if (s_tvalid && s_tready)
				expected_events.push_back(classify_edge(s_tuser, s_tdata[0], s_tdata[1],
					s_tdata[tbpc_pkg::TIME_W+1:2]));
		end
		pending_count = expected_events.size();
	end

endmodule

@@ dv/two_button_press_classifier_test.sv @@
`timescale 1ns / 1ps

module two_button_press_classifier_test;

	localparam int LIMIT_CYCLES    = 600000;
	localparam int IDLE_MAX        = 13;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int SQUEEZE_CYCLES  = 400;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic [tbpc_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                           s_tuser = 1'b0;
	logic                           m_tready = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic [tbpc_pkg::CFG_W-1:0]     cfg_data = '0;
	wire                            s_tready;
	wire                            m_tvalid;
	wire [tbpc_pkg::M_TDATA_W-1:0]  m_tdata;
	wire                            cfg_ready;
	int                             pending;
	int                             failures;

	// Stimulus control
	bit                             idling = 1'b1;
	bit                             squeeze = 1'b0;
	bit                             stall_rx = 1'b0;
	logic [tbpc_pkg::CFG_W-1:0]     threshold = tbpc_pkg::LONG_PRESS_RESET;
	logic [tbpc_pkg::TIME_W-1:0]    clock_ms = '0;
	logic                           orange_lv = 1'b1;
	logic                           blue_lv = 1'b1;
	int                             sent = 0;
	int                             cycles = 0;

	two_button_press_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	press_event_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.pending_count(pending), .failures(failures)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("[two_button_press_classifier] ERROR");
			$finish;
		end
	end

	// Result sink: random gap per item while idling, plus one long hold-off
	initial begin
		int gap;
		forever begin
			gap = idling ? $urandom_range(0, IDLE_MAX) : 0;
			if (gap > 0 || stall_rx) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (stall_rx) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(negedge clk);
			while (!m_tvalid) @(negedge clk);
			@(posedge clk);
		end
	end

	// Long receiver hold-off, counted here so the sender keeps pushing
	initial begin
		wait (squeeze);
		@(negedge clk);
		stall_rx = 1'b1;
		repeat (SQUEEZE_CYCLES) @(negedge clk);
		stall_rx = 1'b0;
	end

	task automatic send_edge(input logic func, input logic blue_l, input logic orange_l,
			input logic [tbpc_pkg::TIME_W-1:0] now);
		int gap;
		gap = idling ? $urandom_range(0, IDLE_MAX) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= tbpc_pkg::S_TDATA_W'({now, orange_l, blue_l});
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		sent++;
	endtask

	// Stop offering and let every pending result drain
	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [tbpc_pkg::CFG_W-1:0] value);
		go_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		threshold = value;
	endtask

	// Move one button to a level and send the edge at the current time
	task automatic move_button(input logic func, input logic level);
		if (func == tbpc_pkg::FUNC_ORANGE)
			orange_lv = level;
		else
			blue_lv = level;
		send_edge(func, blue_lv, orange_lv, clock_ms);
	endtask

	// Held time, often near the long press boundary
	function automatic logic [tbpc_pkg::TIME_W-1:0] pick_span();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return tbpc_pkg::TIME_W'(threshold);
			2: return tbpc_pkg::TIME_W'(threshold) + 1;
			3: return tbpc_pkg::TIME_W'(threshold) - 1;
			4: return tbpc_pkg::TIME_W'($urandom_range(0, threshold));
			5: return tbpc_pkg::TIME_W'(threshold) +
				tbpc_pkg::TIME_W'($urandom_range(1, 3000));
			6: return $urandom;
			default: return tbpc_pkg::TIME_W'($urandom_range(0, 50));
		endcase
	endfunction

	// One user gesture: single press, chord, lone edge or noise
	task automatic play_gesture();
		int   kind;
		logic first;
		logic rel;
		kind = $urandom_range(0, 9);
		first = 1'($urandom_range(0, 1));
		if (kind < 4) begin
			move_button(first, 1'b0);
			clock_ms += pick_span();
			move_button(first, 1'b1);
		end else if (kind < 8) begin
			move_button(first, 1'b0);
			if ($urandom_range(0, 3) != 0)
				clock_ms += pick_span();
			move_button(~first, 1'b0);
			clock_ms += pick_span();
			rel = 1'($urandom_range(0, 1));
			move_button(rel, 1'b1);
			clock_ms += pick_span();
			move_button(~rel, 1'b1);
		end else if (kind == 8)
			send_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), $urandom);
		else
			move_button(first, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 19) == 0)
			clock_ms = $urandom;
		else
			clock_ms += tbpc_pkg::TIME_W'($urandom_range(0, 5000));
	endtask

	initial begin
		logic [tbpc_pkg::CFG_W-1:0] settings[8];
		int                         target;
		settings = '{16'd0, 16'hFFFF, 16'd1000, 16'd1, 16'd0, 16'd200, 16'hFFFE, 16'd0};
		settings[4] = tbpc_pkg::CFG_W'($urandom_range(0, 65535));
		settings[7] = tbpc_pkg::CFG_W'($urandom_range(2, 5000));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges at the reset threshold of 1000 ms
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b1, 32'd0);        // release, no press seen
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b1, 1'b1, 32'hFFFF_FFFF);  // release, no press, long
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b0, 32'd100);
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b1, 32'd1100);     // exactly at threshold: short
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b0, 32'd200);
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b1, 32'd1201);     // one above: long
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b0, 1'b1, 32'd3000);
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b1, 1'b1, 32'd3500);
		// long chord, orange first, then muted orange release
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b0, 32'd5000);
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b0, 1'b0, 32'd5001);
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b1, 1'b0, 32'd7000);
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b1, 32'd7100);
		// long chord with equal press times
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b0, 32'd9000);
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b0, 1'b0, 32'd9000);
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b1, 32'd11000);
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b1, 1'b1, 32'd11001);
		// short chord gives nothing and mutes the other release
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b0, 32'd20000);
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b0, 1'b0, 32'd20010);
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b1, 32'd20020);
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b1, 1'b1, 32'd20030);
		// chord across the timestamp wrap, blue first
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b0, 1'b1, 32'hFFFF_FFF0);
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b0, 1'b0, 32'd16);
		send_edge(tbpc_pkg::FUNC_BLUE, 1'b1, 1'b0, 32'd1000);
		send_edge(tbpc_pkg::FUNC_ORANGE, 1'b1, 1'b1, 32'd1100);

		// Random gestures over several thresholds
		clock_ms = $urandom;
		foreach (settings[i]) begin
			write_threshold(settings[i]);
			idling = (i % 3 != 1);
			if (i == 4)
				squeeze = 1'b1;
			target = sent + ITEMS_PER_PHASE;
			while (sent < target)
				play_gesture();
		end

		go_idle();
		repeat (6) @(posedge clk);
		if (failures == 0)
			$display("[two_button_press_classifier] OK");
		else
			$display("[two_button_press_classifier] ERROR");
		$finish;
	end

endmodule
